// File: rtl/bhx_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the binhex rle and 6-bit encoder
// no dependencies

package bhx_pkg;

    localparam int unsigned MAX_RUN_DEF = 255;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned ENTRY_BYTES = 4;
    localparam int unsigned NBYTES_W    = $clog2(ENTRY_BYTES + 1);

    localparam logic       MODE_DATA   = 1'b0;
    localparam logic       MODE_FINISH = 1'b1;
    localparam logic [7:0] RUN_MARK    = 8'h90;

    // encoded bytes produced by one input word, plus flush request
    typedef struct packed {
        logic [ENTRY_BYTES-1:0][7:0] bytes;
        logic [NBYTES_W-1:0]         nbytes;
        logic                        flush;
    } entry_t;

    localparam logic [7:0] ALPHABET [64] = '{
        8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
        8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h30, 8'h31, 8'h32,
        8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
        8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
        8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5A, 8'h5B,
        8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
        8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h70, 8'h71, 8'h72
    };

endpackage

// File: rtl/bhx_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for input bytes and output characters
// no dependencies

interface bhx_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface bhx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: rtl/binhex_encode_rle_8to6_unit.sv
`timescale 1ns / 1ps
// binhex 4.0 run-length coder and 8-to-6 character encoder, top level
// depends on bhx_pkg, bhx_if, bhx_front, bhx_queue, bhx_back
// words are registered in the queue, characters in the output register
// throughput: one input word per cycle into a two-entry queue while it is
// not full; the packer emits one character per cycle unless output stalls
// reset: asynchronous, no pending byte, run count one, symbol phase zero

module binhex_encode_rle_8to6_unit #(
    parameter int unsigned MAX_RUN = bhx_pkg::MAX_RUN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bhx_in_if.sink    din,
    bhx_out_if.source dout
);
    import bhx_pkg::*;

    logic   q_push, q_pop, q_full, q_valid;
    entry_t q_entry, q_head;

    bhx_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    bhx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    bhx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (q_head),
        .q_pop   (q_pop),
        .dout    (dout)
    );

endmodule

// File: rtl/bhx_front.sv
`timescale 1ns / 1ps
// front end: accepts input words, does run-length coding, emits encoded byte groups
// depends on bhx_pkg and bhx_in_if

module bhx_front #(
    parameter int unsigned MAX_RUN = bhx_pkg::MAX_RUN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    bhx_in_if.sink          din,
    input  logic            q_full,
    output logic            q_push,
    output bhx_pkg::entry_t q_entry
);
    import bhx_pkg::*;

    logic [7:0] prev_byte_reg, prev_byte_next;
    logic       prev_valid_reg, prev_valid_next;
    logic [7:0] run_count_reg, run_count_next;

    logic       accept;
    logic       is_rep;
    logic [1:0] nrun;
    logic [7:0] run0, run1;
    logic [1:0] nlit;
    logic [7:0] lit0;
    entry_t     ent;

    assign din.ready = !q_full;
    assign accept    = din.valid && din.ready;
    assign is_rep    = prev_valid_reg && (din.data_byte == prev_byte_reg);
    assign lit0      = din.data_byte;
    assign nlit      = (din.data_byte == RUN_MARK) ? 2'd2 : 2'd1;

    // bytes that close the pending run
    always_comb
    begin
        nrun = 2'd0;
        run0 = RUN_MARK;
        run1 = run_count_reg;
        if (run_count_reg > 8'd1)
        begin
            if (run_count_reg == 8'd2 && prev_byte_reg != RUN_MARK)
            begin
                nrun = 2'd1;
                run0 = prev_byte_reg;
            end
            else
            begin
                nrun = 2'd2;
            end
        end
    end

    always_comb
    begin
        ent             = '0;
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        run_count_next  = run_count_reg;
        if (din.mode == MODE_DATA)
        begin
            if (is_rep)
            begin
                if (run_count_reg < 8'(MAX_RUN))
                begin
                    run_count_next = run_count_reg + 8'd1;
                end
                else
                begin
                    ent.bytes[0]   = RUN_MARK;
                    ent.bytes[1]   = run_count_reg;
                    ent.nbytes     = NBYTES_W'(2);
                    run_count_next = 8'd2;
                end
            end
            else
            begin
                // literal after the closing bytes; 0x90 gets a zero escape
                unique case (nrun)
                    2'd0:
                    begin
                        ent.bytes[0] = lit0;
                    end
                    2'd1:
                    begin
                        ent.bytes[0] = run0;
                        ent.bytes[1] = lit0;
                    end
                    default:
                    begin
                        ent.bytes[0] = run0;
                        ent.bytes[1] = run1;
                        ent.bytes[2] = lit0;
                    end
                endcase
                ent.nbytes      = NBYTES_W'(nrun) + NBYTES_W'(nlit);
                prev_byte_next  = din.data_byte;
                prev_valid_next = 1'b1;
                run_count_next  = 8'd1;
            end
        end
        else
        begin
            ent.bytes[0]    = run0;
            ent.bytes[1]    = run1;
            ent.nbytes      = NBYTES_W'(nrun);
            ent.flush       = 1'b1;
            prev_byte_next  = 8'd0;
            prev_valid_next = 1'b0;
            run_count_next  = 8'd1;
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && ((ent.nbytes != '0) || ent.flush);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= 8'd0;
            prev_valid_reg <= 1'b0;
            run_count_reg  <= 8'd1;
        end
        else if (accept)
        begin
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            run_count_reg  <= run_count_next;
        end
    end

endmodule

// File: rtl/bhx_queue.sv
`timescale 1ns / 1ps
// small fifo of encoded byte groups between front and back
// depends on bhx_pkg

module bhx_queue #(
    parameter int unsigned DEPTH = bhx_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bhx_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output bhx_pkg::entry_t head
);
    import bhx_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/bhx_back.sv
`timescale 1ns / 1ps
// back end: packs encoded bytes in 6-bit symbols, one char per ready cycle
// depends on bhx_pkg and bhx_out_if

module bhx_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  bhx_pkg::entry_t head,
    output logic            q_pop,
    bhx_out_if.source       dout
);
    import bhx_pkg::*;

    logic [1:0]          phase_reg, phase_next;
    logic [5:0]          carry_reg, carry_next;
    logic                sub_reg, sub_next;
    logic [NBYTES_W-1:0] idx_reg, idx_next;
    logic                out_valid_reg;
    logic [7:0]          out_char_reg;
    logic                out_last_reg;

    logic                can_step, step;
    logic                emit, last;
    logic [5:0]          sym;
    logic [7:0]          cur;
    logic                adv;

    assign can_step = !out_valid_reg || dout.ready;
    assign step     = can_step && q_valid;
    assign cur      = head.bytes[idx_reg[1:0]];

    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        sub_next   = sub_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        last       = 1'b0;
        sym        = carry_reg;
        adv        = 1'b0;
        q_pop      = 1'b0;
        if (idx_reg < head.nbytes)
        begin
            emit = 1'b1;
            unique case (phase_reg)
                2'd1:
                begin
                    sym        = {2'b00, cur[7:4]} | carry_reg;
                    carry_next = {cur[3:0], 2'b00};
                    phase_next = 2'd2;
                    adv        = 1'b1;
                end
                2'd2:
                begin
                    if (!sub_reg)
                    begin
                        sym      = {4'b0000, cur[7:6]} | carry_reg;
                        sub_next = 1'b1;
                    end
                    else
                    begin
                        sym        = cur[5:0];
                        carry_next = 6'd0;
                        phase_next = 2'd0;
                        sub_next   = 1'b0;
                        adv        = 1'b1;
                    end
                end
                default:
                begin
                    sym        = cur[7:2];
                    carry_next = {cur[1:0], 4'b0000};
                    phase_next = 2'd1;
                    adv        = 1'b1;
                end
            endcase
            if (adv)
            begin
                if (idx_reg + 1'b1 == head.nbytes && !(head.flush && phase_next != 2'd0))
                begin
                    last     = 1'b1;
                    q_pop    = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
        else
        begin
            // flush step: leftover bits go out zero padded
            emit       = (phase_reg != 2'd0);
            last       = 1'b1;
            sym        = carry_reg;
            q_pop      = 1'b1;
            idx_next   = '0;
            phase_next = 2'd0;
            carry_next = 6'd0;
            sub_next   = 1'b0;
        end
        if (!step)
        begin
            q_pop = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            carry_reg     <= 6'd0;
            sub_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                carry_reg <= carry_next;
                sub_reg   <= sub_next;
                idx_reg   <= idx_next;
            end
            if (can_step)
            begin
                out_valid_reg <= step && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_char_reg <= ALPHABET[sym];
            out_last_reg <= last;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.out_char = out_char_reg;
    assign dout.last     = out_last_reg;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for binhex_encode_rle_8to6_unit: rle and 6-bit symbol predictor,
// random pacing on both channels, directed and random byte streams
// depends on bhx_pkg, bhx_if and the rtl of binhex_encode_rle_8to6_unit

module tb;

    localparam int RUN_LIMIT    = bhx_pkg::MAX_RUN_DEF;
    localparam int MAX_CHARS    = 6;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 16;

    // binhex 4.0 character set, octal escape stands for the backquote
    localparam logic [0:63][7:0] SYMBOLS =
        "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[\140abcdefhijklmpqr";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } bhx_char_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bhx_in_if  din_if ();
    bhx_out_if dout_if ();

    binhex_encode_rle_8to6_unit #(
        .MAX_RUN (RUN_LIMIT)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // pacing controls shared by the test tasks and the sink process, and the failure count
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int hold_off    = 0;
    int fail_cnt    = 0;

    // encoder state mirror
    logic [7:0] last_byte;
    logic       have_byte;
    logic [7:0] run_len;
    logic [1:0] sym_phase;
    logic [5:0] spill_bits;

    logic [7:0] word_chars [$];
    bhx_char_t  exp_chars [$];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_encoder();
        last_byte  = 8'h00;
        have_byte  = 1'b0;
        run_len    = 8'd1;
        sym_phase  = 2'd0;
        spill_bits = 6'd0;
    endfunction

    function automatic void emit_sym(logic [5:0] s);
        word_chars.push_back(SYMBOLS[s]);
    endfunction

    // msb-first packing, three bytes into four symbols
    function automatic void pack_byte(logic [7:0] c);
        case (sym_phase)
            2'd1:
            begin
                emit_sym({2'b00, c[7:4]} | spill_bits);
                spill_bits = {c[3:0], 2'b00};
                sym_phase  = 2'd2;
            end
            2'd2:
            begin
                emit_sym({4'b0000, c[7:6]} | spill_bits);
                emit_sym(c[5:0]);
                spill_bits = 6'd0;
                sym_phase  = 2'd0;
            end
            default:
            begin
                emit_sym(c[7:2]);
                spill_bits = {c[1:0], 4'b0000};
                sym_phase  = 2'd1;
            end
        endcase
    endfunction

    function automatic void close_run();
        if (run_len > 8'd1)
        begin
            if (run_len == 8'd2 && last_byte != bhx_pkg::RUN_MARK)
                pack_byte(last_byte);
            else
            begin
                pack_byte(bhx_pkg::RUN_MARK);
                pack_byte(run_len);
            end
        end
        run_len = 8'd1;
    endfunction

    function automatic void predict_word(logic m, logic [7:0] b);
        word_chars.delete();
        if (m == bhx_pkg::MODE_DATA)
        begin
            if (have_byte && b == last_byte)
            begin
                if (run_len < RUN_LIMIT)
                    run_len = run_len + 8'd1;
                else
                begin
                    // full run goes out, the held copy starts the next one
                    pack_byte(bhx_pkg::RUN_MARK);
                    pack_byte(run_len);
                    run_len = 8'd2;
                end
            end
            else
            begin
                close_run();
                pack_byte(b);
                if (b == bhx_pkg::RUN_MARK)
                    pack_byte(8'h00);
                last_byte = b;
                have_byte = 1'b1;
            end
        end
        else
        begin
            if (have_byte)
                close_run();
            if (sym_phase == 2'd1 || sym_phase == 2'd2)
                emit_sym(spill_bits);
            clear_encoder();
        end
        for (int k = 0; k < word_chars.size() && k < MAX_CHARS; k++)
            exp_chars.push_back('{ch: word_chars[k],
                                   last: (k == word_chars.size() - 1 || k == MAX_CHARS - 1)});
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && din_if.valid && din_if.ready)
            predict_word(din_if.mode, din_if.data_byte);
    end

    always @(posedge clk)
    begin : char_check
        bhx_char_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (exp_chars.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected word, expected none, actual char %02h last %0b",
                         $time, dout_if.out_char, dout_if.last);
            end
            else
            begin
                want = exp_chars.pop_front();
                if (dout_if.out_char !== want.ch)
                begin
                    fail_cnt++;
                    $display("%0t: out_char mismatch, expected %02h, actual %02h",
                             $time, want.ch, dout_if.out_char);
                end
                if (dout_if.last !== want.last)
                begin
                    fail_cnt++;
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, dout_if.last);
                end
            end
        end
    end

    // output ready pacing, a requested hold-off is counted out here
    initial
    begin : sink_pacing
        int n;
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                dout_if.ready = 1'b0;
                n = hold_off;
                hold_off = 0;
                repeat (n - 1) @(negedge clk);
            end
            else if (sink_steady)
                dout_if.ready = 1'b1;
            else
            begin
                n = pick_gap();
                if (n == 0)
                    dout_if.ready = 1'b1;
                else
                begin
                    dout_if.ready = 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: timeout with %0d chars outstanding", $time, exp_chars.size());
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_word(input logic m, input logic [7:0] b);
        int gap;
        @(negedge clk);
        din_if.valid     = 1'b1;
        din_if.mode      = m;
        din_if.data_byte = b;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            din_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_finish();
        send_word(bhx_pkg::MODE_FINISH, 8'($urandom));
    endtask

    task automatic wait_all_chars();
        @(negedge clk);
        din_if.valid = 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a zero byte right after reset is a real byte, not a repeat
    task automatic test_leading_zero();
        send_word(bhx_pkg::MODE_DATA, 8'h00);
        send_word(bhx_pkg::MODE_DATA, 8'h00);
        send_finish();
        send_finish();
        wait_all_chars();
    endtask

    // finish at each symbol phase, and no repeat across a finish
    task automatic test_flush_phases();
        send_word(bhx_pkg::MODE_DATA, 8'h41);
        send_finish();
        send_word(bhx_pkg::MODE_DATA, 8'h41);
        send_word(bhx_pkg::MODE_DATA, 8'h42);
        send_finish();
        send_word(bhx_pkg::MODE_DATA, 8'h41);
        send_word(bhx_pkg::MODE_DATA, 8'h42);
        send_word(bhx_pkg::MODE_DATA, 8'h43);
        send_finish();
        send_word(bhx_pkg::MODE_DATA, 8'h43);
        send_finish();
        wait_all_chars();
    endtask

    task automatic test_escapes_and_runs();
        send_word(bhx_pkg::MODE_DATA, bhx_pkg::RUN_MARK);
        send_word(bhx_pkg::MODE_DATA, 8'hff);
        send_word(bhx_pkg::MODE_DATA, 8'h11);
        send_word(bhx_pkg::MODE_DATA, 8'h11);
        send_word(bhx_pkg::MODE_DATA, 8'h22);
        repeat (2) send_word(bhx_pkg::MODE_DATA, bhx_pkg::RUN_MARK);
        repeat (3) send_word(bhx_pkg::MODE_DATA, 8'h33);
        repeat (3) send_word(bhx_pkg::MODE_DATA, bhx_pkg::RUN_MARK);
        send_finish();
        wait_all_chars();
    endtask

    // a run past the counter limit
    task automatic test_run_limit();
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        repeat (RUN_LIMIT + 2) send_word(bhx_pkg::MODE_DATA, 8'h5a);
        send_word(bhx_pkg::MODE_DATA, 8'h5b);
        send_finish();
        wait_all_chars();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // sink holds off while the source keeps offering, then source waits for all chars
    task automatic test_backpressure();
        src_steady = 1'b1;
        hold_off   = 300;
        for (int i = 0; i < 30; i++)
            send_word(bhx_pkg::MODE_DATA,
                      ($urandom_range(0, 2) == 0) ? bhx_pkg::RUN_MARK : 8'($urandom));
        send_finish();
        wait_all_chars();
        src_steady = 1'b0;
        for (int i = 0; i < 12; i++)
            send_word(bhx_pkg::MODE_DATA, 8'($urandom));
        send_finish();
        wait_all_chars();
    endtask

    task automatic test_random_streams(input int n_items);
        int         sent;
        int         r;
        int         run;
        logic [7:0] b;
        sent = 0;
        b    = 8'h00;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                src_steady = !src_steady;
            if ($urandom_range(0, 9) == 0)
                sink_steady = !sink_steady;
            if ($urandom_range(0, 99) < 8)
            begin
                send_finish();
                sent++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    b = bhx_pkg::RUN_MARK;
                else if (r < 20)
                    b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
                else if (r >= 35)
                    b = 8'($urandom);
                // otherwise reuse the previous byte, also across a finish
                r = $urandom_range(0, 99);
                if (r < 55)
                    run = 1;
                else if (r < 80)
                    run = 2;
                else if (r < 95)
                    run = $urandom_range(3, 6);
                else
                    run = $urandom_range(7, 30);
                repeat (run) send_word(bhx_pkg::MODE_DATA, b);
                sent += run;
            end
        end
        send_finish();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin : main_seq
        din_if.valid     = 1'b0;
        din_if.mode      = bhx_pkg::MODE_DATA;
        din_if.data_byte = 8'h00;
        clear_encoder();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_leading_zero();
        test_flush_phases();
        test_escapes_and_runs();
        test_run_limit();
        test_backpressure();
        test_random_streams(40);
        wait_all_chars();

        if (fail_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bhx_pkg.sv
rtl/bhx_if.sv
rtl/bhx_front.sv
rtl/bhx_queue.sv
rtl/bhx_back.sv
rtl/binhex_encode_rle_8to6_unit.sv
dv/tb.sv
